@@ hw/rtl/lsrd_pkg.sv @@
// lamp shift register driver: shared types and constants
package lsrd_pkg;

   // fixed widths of the beat fields
   localparam int FieldW = 48;
   localparam int BitsPerByte = 8;
   localparam int MaxBytes = 8;
   localparam int MaxImgW = MaxBytes * BitsPerByte;
   localparam int NUM_BYTES_DEFAULT = 6;

   // request beat
   typedef struct packed {
      logic [FieldW-1:0] lamp_mask;
      logic [FieldW-1:0] lamp_value;
      logic              clear_request;
   } req_type;

   // response beat
   typedef struct packed {
      logic serial_bit;
      logic latch_pulse;
      logic clear_pulse;
      logic last;
   } rsp_type;

   // command from the image keeper to the serializer
   typedef struct packed {
      logic shift;
      logic clear;
   } cmd_type;

endpackage

@@ hw/rtl/lamp_shift_register_driver.sv @@
// lamp shift register driver top level
//
// Drives a chain of serial-in parallel-out lamp registers from a stored image.
// Request beats carry a mask, a value and a clear flag; the image becomes
// (image & ~mask) | (value & mask). When that changes the image, the block
// sends NUM_BYTES*8 response beats with one serial bit each (lowest byte
// first, most significant bit of each byte first) and then one latch beat
// marked last. An update that leaves the image unchanged gives no beats. A
// clear request gives a single clear beat marked last and zeroes the image.
// The command from an accepted request sets the sequencer state register, and
// each beat then passes through the output register before it is valid. The
// shift register gives one serial bit per cycle while the receiver does not
// stall; a new request is taken once the serializer has handed its last beat
// to the output register.
// When the receiver stalls, the output register holds its beat and the
// serializer waits. Reset zeroes the image and drops all pending beats.
module lamp_shift_register_driver #(
   parameter int NUM_BYTES = lsrd_pkg::NUM_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsrd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsrd_pkg::rsp_type rsp_data
);

   localparam int ImgW = NUM_BYTES * lsrd_pkg::BitsPerByte;

   lsrd_pkg::cmd_type cmd;
   logic [ImgW-1:0]   next_image;
   logic              ser_idle;
   logic              accept;

   // requests are taken while the serializer is free
   assign req_ready = ser_idle;
   assign accept    = req_valid && ser_idle;

   lsrd_image #(
      .NUM_BYTES(NUM_BYTES)
   ) u_image (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .cmd        (cmd),
      .next_image (next_image)
   );

   lsrd_serializer #(
      .NUM_BYTES(NUM_BYTES)
   ) u_serializer (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_image (next_image),
      .idle       (ser_idle),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hw/rtl/lsrd_image.sv @@
// lamp image register with masked merge and change detection
module lsrd_image #(
   parameter int NUM_BYTES = lsrd_pkg::NUM_BYTES_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  lsrd_pkg::req_type                        req_data,
   output lsrd_pkg::cmd_type                        cmd,
   output logic [NUM_BYTES*lsrd_pkg::BitsPerByte-1:0] next_image
);

   localparam int ImgW = NUM_BYTES * lsrd_pkg::BitsPerByte;
   localparam int PadW = lsrd_pkg::MaxImgW - lsrd_pkg::FieldW;

   logic [ImgW-1:0]              image_ff;
   logic [ImgW-1:0]              image_in;
   logic [lsrd_pkg::MaxImgW-1:0] mask_ext;
   logic [lsrd_pkg::MaxImgW-1:0] value_ext;
   logic [ImgW-1:0]              mask;
   logic [ImgW-1:0]              value;
   logic [ImgW-1:0]              merged;
   logic                         changed;

   // fit the fields to the image width
   assign mask_ext  = {{PadW{1'b0}}, req_data.lamp_mask};
   assign value_ext = {{PadW{1'b0}}, req_data.lamp_value};
   assign mask      = mask_ext[ImgW-1:0];
   assign value     = value_ext[ImgW-1:0];

   // masked merge and compare against the stored image
   assign merged  = (image_ff & ~mask) | (value & mask);
   assign changed = (merged != image_ff);

   // command for the serializer, only in the accept cycle
   always_comb begin
      cmd.clear  = accept && req_data.clear_request;
      cmd.shift  = accept && !req_data.clear_request && changed;
      next_image = merged;
      image_in   = image_ff;
      if (cmd.clear) begin
         image_in = '0;
      end else if (cmd.shift) begin
         image_in = merged;
      end
   end

   // image register
   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff <= '0;
      end else begin
         image_ff <= image_in;
      end
   end

endmodule

@@ hw/rtl/lsrd_serializer.sv @@
// bit serializer with latch and clear strobes and an output register
module lsrd_serializer #(
   parameter int NUM_BYTES = lsrd_pkg::NUM_BYTES_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  lsrd_pkg::cmd_type                          cmd,
   input  logic [NUM_BYTES*lsrd_pkg::BitsPerByte-1:0] load_image,
   output logic                                       idle,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output lsrd_pkg::rsp_type                          rsp_data
);

   localparam int ByteW = lsrd_pkg::BitsPerByte;
   localparam int ImgW  = NUM_BYTES * ByteW;
   localparam int CntW  = $clog2(ImgW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_LATCH,
      ST_CLEAR
   } state_type;

   state_type         state_ff, state_in;
   logic [ImgW-1:0]   sr_ff, sr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lsrd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [ImgW-1:0]   load_bits;
   lsrd_pkg::rsp_type beat;
   logic              beat_valid;
   logic              slot_free;
   logic              advance;

   // reverse bits inside each byte so bit 0 always goes out next
   for (genvar b = 0; b < NUM_BYTES; b++) begin : g_byte
      for (genvar j = 0; j < ByteW; j++) begin : g_bit
         assign load_bits[b*ByteW+j] = load_image[b*ByteW+ByteW-1-j];
      end
   end

   // beat offered by the current state
   always_comb begin
      beat       = '0;
      beat_valid = 1'b0;
      case (state_ff)
         ST_SHIFT: begin
            beat_valid      = 1'b1;
            beat.serial_bit = sr_ff[0];
         end
         ST_LATCH: begin
            beat_valid       = 1'b1;
            beat.latch_pulse = 1'b1;
            beat.last        = 1'b1;
         end
         ST_CLEAR: begin
            beat_valid       = 1'b1;
            beat.clear_pulse = 1'b1;
            beat.last        = 1'b1;
         end
         default: begin
            beat_valid = 1'b0;
         end
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign advance   = beat_valid && slot_free;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      sr_in    = sr_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.clear) begin
               state_in = ST_CLEAR;
            end else if (cmd.shift) begin
               state_in = ST_SHIFT;
               sr_in    = load_bits;
               cnt_in   = CntW'(ImgW - 1);
            end
         end
         ST_SHIFT: begin
            if (advance) begin
               sr_in = sr_ff >> 1;
               if (cnt_ff == '0) begin
                  state_in = ST_LATCH;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         ST_LATCH, ST_CLEAR: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = beat;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sr_ff       <= sr_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
